### design/lfm_pkg.sv
// Shared types, constants and helper functions for the lidar median N-of-M filter.
// No dependencies; imported by every module in the design folder.
`default_nettype none

package lfm_pkg;

    localparam int LFM_WINDOW   = 5;
    localparam int LFM_MED_TAPS = 2;
    localparam int LFM_CHAIN    = (LFM_WINDOW > LFM_MED_TAPS) ? LFM_WINDOW : LFM_MED_TAPS;
    localparam int LFM_CNT_W    = $clog2(LFM_WINDOW + 1);
    localparam int LFM_NEED_W   = 3;
    localparam int LFM_CMP_W    = (LFM_CNT_W > LFM_NEED_W) ? LFM_CNT_W : LFM_NEED_W;
    localparam int LFM_IDX_W    = 3;
    localparam int LFM_DATA_W   = 16;
    localparam int LFM_ID_W     = 11;

    localparam logic [15:0]         RST_MIN_STRENGTH = 16'd1000;
    localparam logic [15:0]         RST_MIN_DISTANCE = 16'd30;
    localparam logic [15:0]         RST_MAX_DISTANCE = 16'd200;
    localparam logic [LFM_NEED_W-1:0] RST_NEEDED     = 3'd3;
    localparam logic [LFM_ID_W-1:0] RST_SENSOR_A_ID  = 11'h101;
    localparam logic [LFM_ID_W-1:0] RST_SENSOR_B_ID  = 11'h102;

    localparam logic [3:0] LEN_FULL = 4'd4;
    localparam logic [3:0] LEN_FAN  = 4'd5;

    typedef enum logic [LFM_IDX_W-1:0] {
        CFG_MIN_STRENGTH  = 3'd0,
        CFG_MIN_DISTANCE  = 3'd1,
        CFG_MAX_DISTANCE  = 3'd2,
        CFG_NEEDED_PASSES = 3'd3,
        CFG_SENSOR_A_ID   = 3'd4,
        CFG_SENSOR_B_ID   = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [15:0]            str_floor;
        logic [15:0]            min_distance;
        logic [15:0]            max_distance;
        logic [LFM_NEED_W-1:0]  needed_passes;
    } gate_cfg_t;

    typedef struct packed {
        logic [15:0] distance;
        logic [15:0] strength;
        logic        valid;
    } flt_res_t;

    function automatic logic [15:0] mid3(input logic [15:0] x, input logic [15:0] y,
                                         input logic [15:0] z);
        logic [15:0] lo;
        logic [15:0] hi;
        logic [15:0] m;
        lo = (x < y) ? x : y;
        hi = (x < y) ? y : x;
        if (z <= lo)
        begin
            m = lo;
        end
        else if (z >= hi)
        begin
            m = hi;
        end
        else
        begin
            m = z;
        end
        return m;
    endfunction

endpackage

`default_nettype wire

### design/lfm_cell.sv
// One cell of the filter history chain: a distance tap and a gate pass mark.
// Depends on lfm_pkg; instantiated in a row by lfm_filter.
`default_nettype none

module lfm_cell (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        adv,
    input  wire logic [15:0] dist_in,
    input  wire logic        mark_in,
    output logic [15:0]      dist_q,
    output logic             mark
);
    import lfm_pkg::*;

    logic [15:0] dist_reg;
    logic        mark_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_reg <= '0;
            mark_reg <= 1'b0;
        end
        else if (adv)
        begin
            dist_reg <= dist_in;
            mark_reg <= mark_in;
        end
    end

    assign dist_q = dist_reg;
    assign mark   = mark_reg;

endmodule

`default_nettype wire

### design/lfm_filter.sv
// Per-sensor filter: chain of lfm_cell history taps, gate check, running pass count, median.
// Depends on lfm_pkg and lfm_cell; gives the result for the transfer being accepted.
`default_nettype none

module lfm_filter (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              adv,
    input  wire logic [15:0]       dist_in,
    input  wire logic [15:0]       str_in,
    input  wire lfm_pkg::gate_cfg_t cfg,
    output lfm_pkg::flt_res_t      res
);
    import lfm_pkg::*;

    logic [15:0]           tap_dist [LFM_CHAIN];
    logic                  tap_mark [LFM_CHAIN];
    logic                  mark_new;
    logic [LFM_CNT_W-1:0]  count_reg;
    logic [LFM_CNT_W-1:0]  count_next;
    logic [15:0]           median;
    logic                  enough;

    assign mark_new = !((str_in < cfg.str_floor) || (dist_in < cfg.min_distance) ||
                        (dist_in > cfg.max_distance));

    for (genvar i = 0; i < LFM_CHAIN; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            lfm_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .adv     (adv),
                .dist_in (dist_in),
                .mark_in (mark_new),
                .dist_q  (tap_dist[i]),
                .mark    (tap_mark[i])
            );
        end
        else
        begin : g_body
            lfm_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .adv     (adv),
                .dist_in (tap_dist[i-1]),
                .mark_in (tap_mark[i-1]),
                .dist_q  (tap_dist[i]),
                .mark    (tap_mark[i])
            );
        end
    end

    // drop the oldest mark, add the new one
    assign count_next = count_reg + LFM_CNT_W'(mark_new) - LFM_CNT_W'(tap_mark[LFM_WINDOW-1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (adv)
        begin
            count_reg <= count_next;
        end
    end

    assign median = mid3(dist_in, tap_dist[0], tap_dist[1]);
    assign enough = LFM_CMP_W'(count_next) >= LFM_CMP_W'(cfg.needed_passes);

    always_comb
    begin
        res.valid    = enough;
        res.distance = enough ? median : 16'd0;
        res.strength = enough ? str_in : 16'd0;
    end

endmodule

`default_nettype wire

### design/lidar_frame_median_nofm_filter_core.sv
// Lidar poll filter top level: frame decode, held readings, two filters, output register.
// Each accepted input transfer has its result registered in the output register.
// Throughput: one poll per cycle; input stalls only while a held result is itself stalled.
// Reset: asynchronous active low; clears configuration to defaults, held values, fan state,
// cell chains and pass counts, and empties the output register. Uses lfm_pkg, lfm_filter.
`default_nettype none

module lidar_frame_median_nofm_filter_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        frame_present,
    input  wire logic [10:0] frame_id,
    input  wire logic [3:0]  frame_length,
    input  wire logic [7:0]  byte0,
    input  wire logic [7:0]  byte1,
    input  wire logic [7:0]  byte2,
    input  wire logic [7:0]  byte3,
    input  wire logic [7:0]  byte4,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [15:0]      raw_distance_a,
    output logic [15:0]      raw_strength_a,
    output logic [15:0]      raw_distance_b,
    output logic [15:0]      raw_strength_b,
    output logic [15:0]      filtered_distance_a,
    output logic [15:0]      filtered_strength_a,
    output logic [15:0]      filtered_distance_b,
    output logic [15:0]      filtered_strength_b,
    output logic             valid_a,
    output logic             valid_b,
    output logic             fan_on
);
    import lfm_pkg::*;

    gate_cfg_t             gate_reg;
    logic [LFM_ID_W-1:0]   sensor_a_id_reg;
    logic [LFM_ID_W-1:0]   sensor_b_id_reg;

    logic [15:0] held_dist_a_reg, held_dist_a_next;
    logic [15:0] held_str_a_reg,  held_str_a_next;
    logic [15:0] held_dist_b_reg, held_dist_b_next;
    logic [15:0] held_str_b_reg,  held_str_b_next;
    logic        fan_reg, fan_next;

    logic        accept;
    logic        full_frame;
    logic        hit_a;
    logic        hit_b;
    logic [15:0] frame_dist;
    logic [15:0] frame_str;

    flt_res_t    res_a;
    flt_res_t    res_b;
    flt_res_t    res_a_reg;
    flt_res_t    res_b_reg;
    logic [15:0] raw_dist_a_reg, raw_str_a_reg, raw_dist_b_reg, raw_str_b_reg;
    logic        fan_out_reg;
    logic        out_valid_reg;

    assign in_stall = out_valid_reg & out_stall;
    assign accept   = in_valid & ~in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gate_reg.str_floor     <= RST_MIN_STRENGTH;
            gate_reg.min_distance  <= RST_MIN_DISTANCE;
            gate_reg.max_distance  <= RST_MAX_DISTANCE;
            gate_reg.needed_passes <= RST_NEEDED;
            sensor_a_id_reg        <= RST_SENSOR_A_ID;
            sensor_b_id_reg        <= RST_SENSOR_B_ID;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_MIN_STRENGTH:  gate_reg.str_floor     <= cfg_data;
                CFG_MIN_DISTANCE:  gate_reg.min_distance  <= cfg_data;
                CFG_MAX_DISTANCE:  gate_reg.max_distance  <= cfg_data;
                CFG_NEEDED_PASSES: gate_reg.needed_passes <= cfg_data[LFM_NEED_W-1:0];
                CFG_SENSOR_A_ID:   sensor_a_id_reg        <= cfg_data[LFM_ID_W-1:0];
                CFG_SENSOR_B_ID:   sensor_b_id_reg        <= cfg_data[LFM_ID_W-1:0];
                default: ;
            endcase
        end
    end

    assign full_frame = frame_present && (frame_length >= LEN_FULL);
    assign hit_a      = full_frame && (frame_id == sensor_a_id_reg);
    assign hit_b      = full_frame && !hit_a && (frame_id == sensor_b_id_reg);
    assign frame_dist = {byte1, byte0};
    assign frame_str  = {byte3, byte2};

    always_comb
    begin
        held_dist_a_next = hit_a ? frame_dist : held_dist_a_reg;
        held_str_a_next  = hit_a ? frame_str  : held_str_a_reg;
        held_dist_b_next = hit_b ? frame_dist : held_dist_b_reg;
        held_str_b_next  = hit_b ? frame_str  : held_str_b_reg;
        fan_next         = fan_reg;
        if ((hit_a || hit_b) && (frame_length >= LEN_FAN))
        begin
            fan_next = (byte4 != 8'd0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_dist_a_reg <= '0;
            held_str_a_reg  <= '0;
            held_dist_b_reg <= '0;
            held_str_b_reg  <= '0;
            fan_reg         <= 1'b0;
        end
        else if (accept)
        begin
            held_dist_a_reg <= held_dist_a_next;
            held_str_a_reg  <= held_str_a_next;
            held_dist_b_reg <= held_dist_b_next;
            held_str_b_reg  <= held_str_b_next;
            fan_reg         <= fan_next;
        end
    end

    lfm_filter u_filter_a (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (accept),
        .dist_in (held_dist_a_next),
        .str_in  (held_str_a_next),
        .cfg     (gate_reg),
        .res     (res_a)
    );

    lfm_filter u_filter_b (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (accept),
        .dist_in (held_dist_b_next),
        .str_in  (held_str_b_next),
        .cfg     (gate_reg),
        .res     (res_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_a_reg      <= res_a;
            res_b_reg      <= res_b;
            raw_dist_a_reg <= held_dist_a_next;
            raw_str_a_reg  <= held_str_a_next;
            raw_dist_b_reg <= held_dist_b_next;
            raw_str_b_reg  <= held_str_b_next;
            fan_out_reg    <= fan_next;
        end
    end

    assign out_valid           = out_valid_reg;
    assign raw_distance_a      = raw_dist_a_reg;
    assign raw_strength_a      = raw_str_a_reg;
    assign raw_distance_b      = raw_dist_b_reg;
    assign raw_strength_b      = raw_str_b_reg;
    assign filtered_distance_a = res_a_reg.distance;
    assign filtered_strength_a = res_a_reg.strength;
    assign filtered_distance_b = res_b_reg.distance;
    assign filtered_strength_b = res_b_reg.strength;
    assign valid_a             = res_a_reg.valid;
    assign valid_b             = res_b_reg.valid;
    assign fan_on              = fan_out_reg;

endmodule

`default_nettype wire
